// ===== rtl/rmq_pkg.sv =====
// Package for the rotation matrix to quaternion unit: widths and helpers.
`timescale 1ns / 1ps
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int W_DATA        = 16;
    localparam int W_ARG         = 19;
    localparam int W_NUM         = 18;
    localparam int W_SQIN        = 50;
    localparam int W_ROOT        = 25;
    localparam int W_QUO         = 17;
    localparam logic [1:0] PC_TRACE = 2'd0;
    localparam logic [1:0] PC_X     = 2'd1;
    localparam logic [1:0] PC_Y     = 2'd2;
    localparam logic [1:0] PC_Z     = 2'd3;
endpackage

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Top level: pipelined rotation matrix to quaternion converter.
`timescale 1ns / 1ps
// One matrix word enters per cycle and one quaternion word leaves per cycle
// while the output is not stalled. A front stage forms the trace, picks the
// pivot and computes the sqrt argument, a pipelined bit-per-stage square root
// follows (its root width is W_ROOT at the default FRAC_BITS), a setup stage
// takes the numerator magnitudes, then a bank of three pipelined restoring
// dividers (one quotient bit per stage) produces the other three components,
// and a final stage rounds, saturates and places them. A stall freezes the
// whole pipeline; i_stall is passed back as o_stall only while the output
// holds a word.
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_m00, input logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02, input logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11, input logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20, input logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_qw, output logic signed [15:0] o_qx,
    output logic signed [15:0] o_qy, output logic signed [15:0] o_qz,
    output logic [1:0]  o_pivot_case,
    output logic        o_saturated
);
    import rmq_pkg::*;

    localparam int W_A     = (FRAC_BITS + 2 > W_ARG) ? FRAC_BITS + 2 : W_ARG;
    localparam int W_SQR   = W_A + FRAC_BITS - 3 + ((W_A + FRAC_BITS - 3) % 2);
    localparam int W_SQ    = (W_SQR > W_SQIN) ? W_SQR : W_SQIN;
    localparam int W_RT    = W_SQ / 2;
    localparam int SQ_STG  = W_RT;
    localparam int DV_BITS = W_NUM + FRAC_BITS + 1;
    localparam int DV_STG  = DV_BITS;
    localparam int W_DEN   = W_RT + 3;
    localparam int W_REM   = W_DEN + 1;
    localparam int N_STG   = 1 + SQ_STG + 1 + DV_STG + 1;

    typedef struct packed {
        logic [1:0] pc;
        logic       flag;
        logic signed [W_NUM-1:0] n0, n1, n2;
    } t_side;

    logic adv;
    logic [N_STG-1:0] r_v;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // front stage
    logic signed [W_A-1:0] t, a, one;
    logic [1:0] pc;
    logic signed [W_NUM-1:0] d21, d02, d10, s01, s02, s12;
    t_side n_f;
    always_comb begin
        one = W_A'(1) <<< FRAC_BITS;
        t = W_A'(i_m00) + W_A'(i_m11) + W_A'(i_m22);
        d21 = W_NUM'(i_m21) - W_NUM'(i_m12);
        d02 = W_NUM'(i_m02) - W_NUM'(i_m20);
        d10 = W_NUM'(i_m10) - W_NUM'(i_m01);
        s01 = W_NUM'(i_m01) + W_NUM'(i_m10);
        s02 = W_NUM'(i_m02) + W_NUM'(i_m20);
        s12 = W_NUM'(i_m12) + W_NUM'(i_m21);
        priority if (t > 0) begin
            pc = PC_TRACE; a = t + one;
        end else if (i_m00 > i_m11 && i_m00 > i_m22) begin
            pc = PC_X; a = one + W_A'(i_m00) - W_A'(i_m11) - W_A'(i_m22);
        end else if (i_m11 > i_m22) begin
            pc = PC_Y; a = one + W_A'(i_m11) - W_A'(i_m00) - W_A'(i_m22);
        end else begin
            pc = PC_Z; a = one + W_A'(i_m22) - W_A'(i_m00) - W_A'(i_m11);
        end
        n_f.pc = pc;
        n_f.flag = a[W_A-1];
        unique case (pc)
            PC_TRACE: begin n_f.n0 = d21; n_f.n1 = d02; n_f.n2 = d10; end
            PC_X:     begin n_f.n0 = d21; n_f.n1 = s01; n_f.n2 = s02; end
            PC_Y:     begin n_f.n0 = d02; n_f.n1 = s01; n_f.n2 = s12; end
            default:  begin n_f.n0 = d10; n_f.n1 = s02; n_f.n2 = s12; end
        endcase
    end
    logic [W_SQ-1:0] n_sqin;
    assign n_sqin = a[W_A-1] ? '0
                  : W_SQ'({{(W_SQ-W_A){1'b0}}, a} << (FRAC_BITS - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[N_STG-2:0], i_valid};
    end

    // square root pipeline
    logic [W_SQ-1:0] r_sv [SQ_STG+1];
    logic [W_RT-1:0] r_sr [SQ_STG+1];
    t_side           r_ss [SQ_STG+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sv[0] <= n_sqin; r_sr[0] <= '0; r_ss[0] <= n_f;
        end
    end
    for (genvar g = 0; g < SQ_STG; g++) begin : g_sq
        localparam int B = SQ_STG - 1 - g;
        logic [W_SQ+1:0] trial, rem;
        logic [W_RT-1:0] root;
        always_comb begin
            trial = {2'b0, W_SQ'({r_sr[g], 2'b01}) << (2 * B)};
            rem = {2'b0, r_sv[g]};
            root = r_sr[g];
            if (rem >= trial) begin
                rem = rem - trial;
                root = (r_sr[g] << 1) | W_RT'(1);
            end else begin
                root = r_sr[g] << 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sv[g+1] <= rem[W_SQ-1:0]; r_sr[g+1] <= root; r_ss[g+1] <= r_ss[g];
            end
        end
    end

    // divider setup
    logic [W_RT-1:0]  r_p;
    t_side            r_ps;
    logic [W_NUM-1:0] r_mag [3];
    logic [2:0]       r_neg;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p <= r_sr[SQ_STG]; r_ps <= r_ss[SQ_STG];
            r_neg <= {r_ss[SQ_STG].n2[W_NUM-1], r_ss[SQ_STG].n1[W_NUM-1],
                      r_ss[SQ_STG].n0[W_NUM-1]};
            r_mag[0] <= r_ss[SQ_STG].n0[W_NUM-1] ? W_NUM'(-r_ss[SQ_STG].n0)
                                                  : W_NUM'(r_ss[SQ_STG].n0);
            r_mag[1] <= r_ss[SQ_STG].n1[W_NUM-1] ? W_NUM'(-r_ss[SQ_STG].n1)
                                                  : W_NUM'(r_ss[SQ_STG].n1);
            r_mag[2] <= r_ss[SQ_STG].n2[W_NUM-1] ? W_NUM'(-r_ss[SQ_STG].n2)
                                                  : W_NUM'(r_ss[SQ_STG].n2);
        end
    end

    // divider pipeline: quotient of (mag << FRAC_BITS) by 4P, plus one half bit
    logic [DV_BITS-1:0] r_dn [DV_STG+1][3];
    logic [W_REM-1:0]   r_dr [DV_STG+1][3];
    logic [DV_BITS-1:0] r_dq [DV_STG+1][3];
    logic [W_RT-1:0]    r_dp [DV_STG+1];
    t_side              r_ds [DV_STG+1];
    logic [2:0]         r_dg [DV_STG+1];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_dn[0][k] = {r_mag[k], {FRAC_BITS{1'b0}}, 1'b0};
            r_dr[0][k] = '0;
            r_dq[0][k] = '0;
        end
        r_dp[0] = r_p; r_ds[0] = r_ps; r_dg[0] = r_neg;
    end
    for (genvar g = 0; g < DV_STG; g++) begin : g_dv
        logic [W_REM-1:0] den;
        assign den = {1'b0, r_dp[g], 2'b00};
        for (genvar k = 0; k < 3; k++) begin : g_ln
            logic [W_REM-1:0] sh;
            logic             ge;
            assign sh = {r_dr[g][k][W_REM-2:0], r_dn[g][k][DV_BITS-1]};
            assign ge = sh >= den;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dn[g+1][k] <= r_dn[g][k] << 1;
                    r_dr[g+1][k] <= ge ? sh - den : sh;
                    r_dq[g+1][k] <= {r_dq[g][k][DV_BITS-2:0], ge};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dp[g+1] <= r_dp[g]; r_ds[g+1] <= r_ds[g]; r_dg[g+1] <= r_dg[g];
            end
        end
    end

    // round, saturate, place
    logic signed [W_DATA-1:0] c [3];
    logic signed [W_DATA-1:0] pv;
    logic fl;
    always_comb begin
        logic [DV_BITS-1:0] q2;
        logic [DV_BITS-1:0] q;
        fl = r_ds[DV_STG].flag;
        for (int k = 0; k < 3; k++) begin
            q2 = r_dq[DV_STG][k];
            q = (q2 >> 1) + DV_BITS'(q2[0]);
            if (r_dp[DV_STG] == '0) begin
                fl = 1'b1;
                c[k] = (r_dg[DV_STG][k]) ? W_DATA'(-32768) : W_DATA'(0);
            end else if (r_dg[DV_STG][k]) begin
                if (q > DV_BITS'(32768)) begin c[k] = W_DATA'(-32768); fl = 1'b1; end
                else c[k] = W_DATA'(-q);
            end else begin
                if (q > DV_BITS'(32767)) begin c[k] = W_DATA'(32767); fl = 1'b1; end
                else c[k] = W_DATA'(q);
            end
        end
        if (r_dp[DV_STG] > W_RT'(32767)) begin pv = W_DATA'(32767); fl = 1'b1; end
        else pv = W_DATA'(r_dp[DV_STG]);
    end
    // zero-divisor sign for positive numerators needs the magnitude; track it
    logic [2:0] r_nz [DV_STG+1];
    always_comb r_nz[0] = {r_mag[2] != '0, r_mag[1] != '0, r_mag[0] != '0};
    for (genvar g = 0; g < DV_STG; g++) begin : g_nz
        always_ff @(posedge i_clk) if (adv) r_nz[g+1] <= r_nz[g];
    end
    logic signed [W_DATA-1:0] cz [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dp[DV_STG] == '0 && !r_dg[DV_STG][k])
                cz[k] = r_nz[DV_STG][k] ? W_DATA'(32767) : W_DATA'(0);
            else
                cz[k] = c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_pivot_case <= r_ds[DV_STG].pc;
            o_saturated  <= fl;
            unique case (r_ds[DV_STG].pc)
                PC_TRACE: begin o_qw <= pv; o_qx <= cz[0]; o_qy <= cz[1]; o_qz <= cz[2]; end
                PC_X:     begin o_qw <= cz[0]; o_qx <= pv; o_qy <= cz[1]; o_qz <= cz[2]; end
                PC_Y:     begin o_qw <= cz[0]; o_qx <= cz[1]; o_qy <= pv; o_qz <= cz[2]; end
                default:  begin o_qw <= cz[0]; o_qx <= cz[1]; o_qy <= cz[2]; o_qz <= pv; end
            endcase
        end
    end
    assign o_valid = r_v[N_STG-1];
endmodule

// ===== rtl/rmq_checker.sv =====
// Port-level checker for the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
module rmq_checker (
    input logic i_clk, input logic i_rst_n, input logic o_stall,
    input logic o_valid, input logic i_stall, input logic [1:0] o_pivot_case,
    input logic o_saturated, input logic signed [15:0] o_qw
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_qw) && $stable(o_pivot_case)
        && $stable(o_saturated)) else $error("word dropped");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("spurious stall");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall) else $error("stall without word");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_pivot_case(o_pivot_case),
    .o_saturated(o_saturated), .o_qw(o_qw)
);
